// ===== hw/rtl/fwfls_pkg.sv =====
// ----------------------------------------------------------------------------
// fwfls_pkg
// Shared types and constants for the FIFO with fill and loss statistics.
// ----------------------------------------------------------------------------
package fwfls_pkg;

  localparam int DEPTH_DEF       = 256;
  localparam int ENTRY_WIDTH_DEF = 32;

  localparam int CMD_W      = 2;
  localparam int DATA_W     = 32;
  localparam int FILL_OUT_W = 8;
  localparam int CNT_W      = 32;
  localparam int OUT_TDATA_W = DATA_W + 2 * FILL_OUT_W + 4 * CNT_W;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

  // Outcome of one command, from the pointer control to the statistics
  typedef struct packed {
    logic push_ok;
    logic pop_ok;
    logic overrun;
    logic underrun;
    logic clear;
  } evt_t;

endpackage

// ===== hw/rtl/fifo_with_fill_and_loss_stats.sv =====
// ----------------------------------------------------------------------------
// fifo_with_fill_and_loss_stats
// Command-driven circular FIFO reporting fill, peak fill and loss counters.
// ----------------------------------------------------------------------------
// Each input beat is one command (push, pop, clear statistics, query) and
// yields exactly one output beat in the cycle after acceptance, so the block
// sustains one command per clock while out_tready stays high. The result
// sits in a single output register; the input is ready whenever that
// register is empty or being drained in the same cycle. Popped data comes
// from the entry memory's registered read port, loaded in the accepting
// cycle. The FIFO holds at most DEPTH-1 entries; the memory needs no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module fifo_with_fill_and_loss_stats #(
  parameter int DEPTH       = fwfls_pkg::DEPTH_DEF,
  parameter int ENTRY_WIDTH = fwfls_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [fwfls_pkg::DATA_W-1:0]       in_tdata,   // write_data
  input  logic [fwfls_pkg::CMD_W-1:0]        in_tuser,   // command
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // read_data, fill_level, peak_fill, overrun_count, underrun_count,
  // push_count, pop_count
  output logic [fwfls_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                               out_tuser   // success
);

  localparam int PW = $clog2(DEPTH);
  localparam int DW = fwfls_pkg::DATA_W;
  localparam int FW = fwfls_pkg::FILL_OUT_W;
  localparam int CW = fwfls_pkg::CNT_W;

  fwfls_pkg::evt_t evt;

  logic                   accept;
  logic                   out_valid_r, out_valid_nxt;
  logic                   success_r;
  logic                   rd_sel_r;
  logic [PW-1:0]          wr_addr;
  logic [PW-1:0]          rd_addr;
  logic [PW-1:0]          fill;
  logic [PW-1:0]          fill_nxt;
  logic [PW-1:0]          peak;
  logic [CW-1:0]          overruns;
  logic [CW-1:0]          underruns;
  logic [CW-1:0]          pushes;
  logic [CW-1:0]          pops;
  logic [63:0]            wr_wide;
  logic [63:0]            rd_wide;
  logic [ENTRY_WIDTH-1:0] rd_entry;
  logic [DW-1:0]          read_data;

  assign in_tready = rst_n && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  fwfls_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .cmd      (in_tuser),
    .evt      (evt),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .fill     (fill),
    .fill_nxt (fill_nxt)
  );

  assign wr_wide = 64'(in_tdata);

  fwfls_store #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (evt.push_ok),
    .wr_addr (wr_addr),
    .wr_data (wr_wide[ENTRY_WIDTH-1:0]),
    .rd_en   (evt.pop_ok),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  fwfls_stats #(
    .DEPTH (DEPTH)
  ) u_stats (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt       (evt),
    .fill_nxt  (fill_nxt),
    .peak      (peak),
    .overruns  (overruns),
    .underruns (underruns),
    .pushes    (pushes),
    .pops      (pops)
  );

  // Load a new result on accept, drop it once the beat is taken
  always_comb begin
    priority if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      success_r   <= 1'b0;
      rd_sel_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        success_r <= evt.push_ok || evt.pop_ok;
        rd_sel_r  <= evt.pop_ok;
      end
    end
  end

  assign rd_wide   = 64'(rd_entry);
  assign read_data = rd_sel_r ? rd_wide[DW-1:0] : '0;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = success_r;
  assign out_tdata  = {pops, pushes, underruns, overruns, FW'(peak), FW'(fill), read_data};

endmodule

// ===== hw/rtl/fwfls_store.sv =====
// ----------------------------------------------------------------------------
// fwfls_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fwfls_store #(
  parameter int DEPTH       = fwfls_pkg::DEPTH_DEF,
  parameter int ENTRY_WIDTH = fwfls_pkg::ENTRY_WIDTH_DEF,
  localparam int PW         = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [PW-1:0]          wr_addr,
  input  logic [ENTRY_WIDTH-1:0] wr_data,
  input  logic                   rd_en,
  input  logic [PW-1:0]          rd_addr,
  output logic [ENTRY_WIDTH-1:0] rd_data
);

  logic [ENTRY_WIDTH-1:0] mem [DEPTH];
  logic [ENTRY_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next pop
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/fwfls_ctrl.sv =====
// ----------------------------------------------------------------------------
// fwfls_ctrl
// Read and write pointers, fill count and the accept or refuse decision.
// ----------------------------------------------------------------------------
module fwfls_ctrl #(
  parameter int DEPTH = fwfls_pkg::DEPTH_DEF,
  localparam int PW   = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [fwfls_pkg::CMD_W-1:0]  cmd,
  output fwfls_pkg::evt_t              evt,
  output logic [PW-1:0]                wr_addr,
  output logic [PW-1:0]                rd_addr,
  output logic [PW-1:0]                fill,
  output logic [PW-1:0]                fill_nxt
);

  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0] fill_r;
  logic          full;
  logic          empty;
  logic          is_push;
  logic          is_pop;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] pos);
    advance = (pos == LAST) ? '0 : pos + PW'(1);
  endfunction

  // At most DEPTH-1 entries: full one short of the array size
  assign full  = (fill_r == LAST);
  assign empty = (fill_r == '0);

  assign is_push = accept && (cmd == fwfls_pkg::CMD_PUSH);
  assign is_pop  = accept && (cmd == fwfls_pkg::CMD_POP);

  always_comb begin
    evt.push_ok  = is_push && !full;
    evt.overrun  = is_push && full;
    evt.pop_ok   = is_pop && !empty;
    evt.underrun = is_pop && empty;
    evt.clear    = accept && (cmd == fwfls_pkg::CMD_CLEAR);
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (evt.push_ok) begin
      wr_ptr_nxt = advance(wr_ptr_r);
      fill_nxt   = fill_r + PW'(1);
    end else if (evt.pop_ok) begin
      rd_ptr_nxt = advance(rd_ptr_r);
      fill_nxt   = fill_r - PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  assign wr_addr = wr_ptr_r;
  assign rd_addr = rd_ptr_r;
  assign fill    = fill_r;

endmodule

// ===== hw/rtl/fwfls_stats.sv =====
// ----------------------------------------------------------------------------
// fwfls_stats
// Event counters and peak fill tracking, cleared on command.
// ----------------------------------------------------------------------------
module fwfls_stats #(
  parameter int DEPTH = fwfls_pkg::DEPTH_DEF,
  localparam int PW   = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fwfls_pkg::evt_t              evt,
  input  logic [PW-1:0]                fill_nxt,
  output logic [PW-1:0]                peak,
  output logic [fwfls_pkg::CNT_W-1:0]  overruns,
  output logic [fwfls_pkg::CNT_W-1:0]  underruns,
  output logic [fwfls_pkg::CNT_W-1:0]  pushes,
  output logic [fwfls_pkg::CNT_W-1:0]  pops
);

  localparam int CW = fwfls_pkg::CNT_W;

  logic [PW-1:0] peak_r, peak_nxt;
  logic [CW-1:0] ovr_r, ovr_nxt;
  logic [CW-1:0] und_r, und_nxt;
  logic [CW-1:0] psh_r, psh_nxt;
  logic [CW-1:0] pop_r, pop_nxt;

  always_comb begin
    peak_nxt = peak_r;
    ovr_nxt  = ovr_r;
    und_nxt  = und_r;
    psh_nxt  = psh_r;
    pop_nxt  = pop_r;
    if (evt.clear) begin
      peak_nxt = '0;
      ovr_nxt  = '0;
      und_nxt  = '0;
      psh_nxt  = '0;
      pop_nxt  = '0;
    end else begin
      if (evt.overrun)  ovr_nxt = ovr_r + CW'(1);
      if (evt.underrun) und_nxt = und_r + CW'(1);
      if (evt.pop_ok)   pop_nxt = pop_r + CW'(1);
      if (evt.push_ok) begin
        psh_nxt = psh_r + CW'(1);
        if (fill_nxt > peak_r) peak_nxt = fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
      ovr_r  <= '0;
      und_r  <= '0;
      psh_r  <= '0;
      pop_r  <= '0;
    end else begin
      peak_r <= peak_nxt;
      ovr_r  <= ovr_nxt;
      und_r  <= und_nxt;
      psh_r  <= psh_nxt;
      pop_r  <= pop_nxt;
    end
  end

  assign peak      = peak_r;
  assign overruns  = ovr_r;
  assign underruns = und_r;
  assign pushes    = psh_r;
  assign pops      = pop_r;

endmodule

// ===== hw/rtl/fwfls_checker.sv =====
// ----------------------------------------------------------------------------
// fwfls_checker
// Port-level checks for the statistics FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module fwfls_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [fwfls_pkg::CMD_W-1:0]        in_tuser,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [fwfls_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                               out_tuser
);

  logic acc;
  assign acc = in_tvalid && in_tready;

  // Every accepted command yields a beat in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_tvalid)
    else $error("no result beat after accepted command");

  // A held result must not change
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed");

  // A refused pop counts exactly one underrun
  a_underrun_count: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_tuser == fwfls_pkg::CMD_POP) |=>
      out_tuser || (out_tdata[111:80] == $past(out_tdata[111:80]) + 32'd1))
    else $error("refused pop did not count an underrun");

  // A refused push counts exactly one overrun
  a_overrun_count: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_tuser == fwfls_pkg::CMD_PUSH) |=>
      out_tuser || (out_tdata[79:48] == $past(out_tdata[79:48]) + 32'd1))
    else $error("refused push did not count an overrun");

  // A query leaves fill untouched and never reports success
  a_query_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_tuser == fwfls_pkg::CMD_QUERY) |=>
      !out_tuser && (out_tdata[39:32] == $past(out_tdata[39:32])))
    else $error("query changed fill or reported success");

endmodule

bind fifo_with_fill_and_loss_stats fwfls_checker u_fwfls_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the command-driven FIFO with fill and loss stats.
// A local mirror of the FIFO and its counters predicts every result beat.
// Directed commands come first, then a fill past full and a drain past
// empty, then a long output stall, then bursts of random traffic. Both
// sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int PTR_W       = $clog2(fwfls_pkg::DEPTH_DEF);
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  // Same bit order as out_tdata: read_data in the lowest bits
  typedef struct packed {
    logic [fwfls_pkg::CNT_W-1:0]      pops;
    logic [fwfls_pkg::CNT_W-1:0]      pushes;
    logic [fwfls_pkg::CNT_W-1:0]      underruns;
    logic [fwfls_pkg::CNT_W-1:0]      overruns;
    logic [fwfls_pkg::FILL_OUT_W-1:0] peak;
    logic [fwfls_pkg::FILL_OUT_W-1:0] fill;
    logic [fwfls_pkg::DATA_W-1:0]     rdata;
  } fifo_stats_t;

  typedef struct packed {
    logic        ok;
    fifo_stats_t stats;
  } fifo_result_t;

  logic                              clk        = 1'b0;
  logic                              rst_n      = 1'b0;
  logic                              in_tvalid  = 1'b0;
  logic [fwfls_pkg::DATA_W-1:0]      in_tdata   = '0;
  logic [fwfls_pkg::CMD_W-1:0]       in_tuser   = fwfls_pkg::CMD_QUERY;
  logic                              out_tready = 1'b0;
  logic                              in_tready;
  logic                              out_tvalid;
  logic [fwfls_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                              out_tuser;

  // Mirror of the FIFO contents and statistics
  logic [fwfls_pkg::DATA_W-1:0] mirror_mem [fwfls_pkg::DEPTH_DEF];
  logic [PTR_W-1:0]             mirror_wr      = '0;
  logic [PTR_W-1:0]             mirror_rd      = '0;
  logic [fwfls_pkg::CNT_W-1:0]  overrun_tally  = '0;
  logic [fwfls_pkg::CNT_W-1:0]  underrun_tally = '0;
  logic [fwfls_pkg::CNT_W-1:0]  push_tally     = '0;
  logic [fwfls_pkg::CNT_W-1:0]  pop_tally      = '0;
  logic [PTR_W-1:0]             peak_mark      = '0;

  fifo_result_t pending_results [$];
  int           mismatch_count = 0;
  bit           send_idle      = 1'b1;
  bit           recv_idle      = 1'b1;
  int unsigned  hold_request   = 0;

  always #1 clk = ~clk;

  fifo_with_fill_and_loss_stats uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  function automatic fifo_result_t apply_command(
    input logic [fwfls_pkg::CMD_W-1:0]  cmd,
    input logic [fwfls_pkg::DATA_W-1:0] wdata
  );
    fifo_result_t     r;
    logic [PTR_W-1:0] nxt;
    logic [PTR_W-1:0] fill;
    r   = '0;
    nxt = mirror_wr + 1'b1;
    case (cmd)
      fwfls_pkg::CMD_PUSH: begin
        if (nxt == mirror_rd) begin
          overrun_tally = overrun_tally + 1'b1;
        end else begin
          mirror_mem[mirror_wr] = wdata;
          mirror_wr             = nxt;
          push_tally            = push_tally + 1'b1;
          fill                  = mirror_wr - mirror_rd;
          if (fill > peak_mark) peak_mark = fill;
          r.ok = 1'b1;
        end
      end
      fwfls_pkg::CMD_POP: begin
        if (mirror_rd == mirror_wr) begin
          underrun_tally = underrun_tally + 1'b1;
        end else begin
          r.stats.rdata = mirror_mem[mirror_rd];
          mirror_rd     = mirror_rd + 1'b1;
          pop_tally     = pop_tally + 1'b1;
          r.ok          = 1'b1;
        end
      end
      fwfls_pkg::CMD_CLEAR: begin
        overrun_tally  = '0;
        underrun_tally = '0;
        push_tally     = '0;
        pop_tally      = '0;
        peak_mark      = '0;
      end
      default: ;
    endcase
    r.stats.fill      = fwfls_pkg::FILL_OUT_W'(mirror_wr - mirror_rd);
    r.stats.peak      = fwfls_pkg::FILL_OUT_W'(peak_mark);
    r.stats.overruns  = overrun_tally;
    r.stats.underruns = underrun_tally;
    r.stats.pushes    = push_tally;
    r.stats.pops      = pop_tally;
    return r;
  endfunction

  function automatic string describe(input fifo_result_t r);
    return $sformatf("ok=%0b rd=%h fill=%0d peak=%0d ovr=%0d und=%0d push=%0d pop=%0d",
                     r.ok, r.stats.rdata, r.stats.fill, r.stats.peak, r.stats.overruns,
                     r.stats.underruns, r.stats.pushes, r.stats.pops);
  endfunction

  // Predict on every accepted input beat, check every accepted output beat
  always @(posedge clk) begin : scoreboard
    fifo_result_t want;
    fifo_result_t got;
    if (rst_n && in_tvalid && in_tready)
      pending_results.push_back(apply_command(in_tuser, in_tdata));
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: %s", describe(got));
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result mismatch, expected: %s", describe(want));
            $display("                 actual:   %s", describe(got));
          end
        end
      end
    end
  end

  // Receiver: random gaps per beat, plus one long hold when requested
  initial begin : receiver
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request != 0) begin
        out_tready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      gap = recv_idle ? $urandom_range(0, 10) : 0;
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Keep tvalid high across back-to-back beats; drop it only for a gap
  task automatic send_cmd(input logic [fwfls_pkg::CMD_W-1:0]  cmd,
                          input logic [fwfls_pkg::DATA_W-1:0] wdata);
    int gap;
    gap = send_idle ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= wdata;
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [fwfls_pkg::CMD_W-1:0] pick_command(input int push_pct,
                                                               input int pop_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct) return fwfls_pkg::CMD_PUSH;
    if (r < push_pct + pop_pct) return fwfls_pkg::CMD_POP;
    if (r < 98) return fwfls_pkg::CMD_QUERY;
    return fwfls_pkg::CMD_CLEAR;
  endfunction

  task automatic test_directed_commands();
    send_cmd(fwfls_pkg::CMD_QUERY, 32'h0000_0000);
    send_cmd(fwfls_pkg::CMD_POP,   32'hFFFF_FFFF);
    send_cmd(fwfls_pkg::CMD_PUSH,  32'h0000_0000);
    send_cmd(fwfls_pkg::CMD_PUSH,  32'hFFFF_FFFF);
    send_cmd(fwfls_pkg::CMD_PUSH,  32'h5555_5555);
    send_cmd(fwfls_pkg::CMD_PUSH,  32'hAAAA_AAAA);
    send_cmd(fwfls_pkg::CMD_QUERY, 32'h1234_5678);
    send_cmd(fwfls_pkg::CMD_POP,   32'h0000_0000);
    send_cmd(fwfls_pkg::CMD_POP,   32'h0000_0000);
    // clear must keep the stored entries
    send_cmd(fwfls_pkg::CMD_CLEAR, 32'hFFFF_FFFF);
    send_cmd(fwfls_pkg::CMD_QUERY, 32'h0000_0000);
    send_cmd(fwfls_pkg::CMD_POP,   32'h0000_0000);
    send_cmd(fwfls_pkg::CMD_POP,   32'h0000_0000);
    send_cmd(fwfls_pkg::CMD_POP,   32'h0000_0000);
    send_cmd(fwfls_pkg::CMD_PUSH,  32'h8000_0001);
    send_cmd(fwfls_pkg::CMD_POP,   32'h0000_0000);
    send_cmd(fwfls_pkg::CMD_CLEAR, 32'h0000_0000);
    send_cmd(fwfls_pkg::CMD_QUERY, 32'h0000_0000);
  endtask

  // Push past full to hit overruns, then pop past empty
  task automatic test_fill_to_full();
    repeat (fwfls_pkg::DEPTH_DEF + 2) send_cmd(fwfls_pkg::CMD_PUSH, $urandom());
    send_cmd(fwfls_pkg::CMD_QUERY, $urandom());
    repeat (fwfls_pkg::DEPTH_DEF + 2) send_cmd(fwfls_pkg::CMD_POP, $urandom());
  endtask

  task automatic test_output_backpressure();
    send_idle    = 1'b0;
    recv_idle    = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (40) send_cmd(pick_command(50, 40), $urandom());
  endtask

  task automatic test_random_traffic(input int n_items);
    int sent;
    int burst;
    int push_pct;
    int pop_pct;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0:       begin push_pct = 85; pop_pct = 10; end
        1:       begin push_pct = 10; pop_pct = 85; end
        default: begin push_pct = 47; pop_pct = 47; end
      endcase
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      repeat (burst) begin
        send_cmd(pick_command(push_pct, pop_pct), $urandom());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_commands();
    test_fill_to_full();
    test_output_backpressure();
    test_random_traffic(1400);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
